@@ hdl/b2p_pkg.sv @@
package b2p_pkg;

    localparam int MAX_PLANES       = 4;
    localparam int MAX_GROUP_BYTES  = 32;
    localparam int PIXEL_COUNT_BITS = 20;

    localparam int BYTE_W     = 8;
    localparam int PIX_W      = 4;
    localparam int PC_W       = 3;
    localparam int GB_W       = 6;
    localparam int IMG_W      = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int IMG_PAD_W  = 24;

    localparam int PLANE_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int M_W     = (MAX_GROUP_BYTES > 1) ? $clog2(MAX_GROUP_BYTES) : 1;
    localparam int LANES   = (MAX_PLANES > 1) ? MAX_PLANES - 1 : 1;
    localparam int ROW_W   = LANES * BYTE_W;
    localparam int USED_W  = PIXEL_COUNT_BITS + 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PC_W-1:0]  PC_RESET  = PC_W'(MAX_PLANES);
    localparam logic [GB_W-1:0]  GB_RESET  = GB_W'(MAX_GROUP_BYTES);
    localparam logic [IMG_W-1:0] IMG_RESET = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLANE_COUNT  = 2'd0,
        CFG_GROUP_BYTES  = 2'd1,
        CFG_BIT_ORDER    = 2'd2,
        CFG_IMAGE_PIXELS = 2'd3
    } cfg_idx_t;

    // effective settings, already clamped
    typedef struct packed {
        logic [PC_W-1:0]             pc;
        logic [GB_W-1:0]             gb;
        logic                        lsb_first;
        logic [PIXEL_COUNT_BITS-1:0] pixels;
        logic                        restart;
    } cfg_t;

    // one last-plane byte and the stored bytes of the leading planes
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [BYTE_W-1:0] byte_val;
        logic [PC_W-1:0]   pc;
        logic              lsb_first;
        logic              img_last;
    } job_t;

    function automatic logic [PIX_W-1:0] pixel_of(job_t j, logic [2:0] pos);
        logic [PIX_W-1:0]  idx;
        logic [BYTE_W-1:0] src;
        logic [PC_W-1:0]   sh;
        idx = '0;
        for (int k = 0; k < MAX_PLANES; k++) begin
            if (PC_W'(k + 1) == j.pc) begin
                src = j.byte_val;
            end
            else if (k < LANES) begin
                src = j.row[k*BYTE_W +: BYTE_W];
            end
            else begin
                src = '0;
            end
            sh = j.lsb_first ? PC_W'(k) : PC_W'(j.pc - PC_W'(k + 1));
            if ((PC_W'(k) < j.pc) && (sh < PC_W'(PIX_W))) begin
                idx[sh[$clog2(PIX_W)-1:0]] = src[3'd7 - pos];
            end
        end
        return idx;
    endfunction

endpackage

@@ hdl/b2p_cfg.sv @@
module b2p_cfg
    import b2p_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [PC_W-1:0]  pc_reg;
    logic [GB_W-1:0]  gb_reg;
    logic             order_reg;
    logic [IMG_W-1:0] img_reg;
    logic             wr;
    logic [IMG_PAD_W-1:0] img_pad;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= PC_RESET;
            gb_reg    <= GB_RESET;
            order_reg <= 1'b0;
            img_reg   <= IMG_RESET;
        end
        else if (wr)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PLANE_COUNT:  pc_reg    <= cfg_data[PC_W-1:0];
                CFG_GROUP_BYTES:  gb_reg    <= cfg_data[GB_W-1:0];
                CFG_BIT_ORDER:    order_reg <= cfg_data[0];
                CFG_IMAGE_PIXELS: img_reg   <= cfg_data[IMG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        img_pad = IMG_PAD_W'(img_reg);
        if (pc_reg == '0)
            cfg.pc = PC_W'(1);
        else if (pc_reg > PC_W'(MAX_PLANES))
            cfg.pc = PC_W'(MAX_PLANES);
        else
            cfg.pc = pc_reg;
        if (gb_reg == '0)
            cfg.gb = GB_W'(1);
        else if (gb_reg > GB_W'(MAX_GROUP_BYTES))
            cfg.gb = GB_W'(MAX_GROUP_BYTES);
        else
            cfg.gb = gb_reg;
        cfg.lsb_first = order_reg;
        cfg.pixels    = img_pad[PIXEL_COUNT_BITS-1:0];
        // every index of the map is a real register, so any write restarts
        cfg.restart   = wr;
    end

endmodule

@@ hdl/b2p_front.sv @@
module b2p_front
    import b2p_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [QCNT_W-1:0] q_count,
    output logic              q_push,
    output job_t              q_job
);

    logic [PLANE_W-1:0] plane_reg, plane_next;
    logic [M_W-1:0]     m_reg, m_next;
    logic [USED_W-1:0]  used_reg, used_next;

    logic               s1_valid_reg;
    logic [BYTE_W-1:0]  s1_byte_reg;
    logic [PC_W-1:0]    s1_pc_reg;
    logic               s1_order_reg;
    logic               s1_last_reg;
    logic [ROW_W-1:0]   rd_row_reg;

    logic [ROW_W-1:0]   store_mem [MAX_GROUP_BYTES];

    logic [USED_W-1:0]  grp_px;
    logic [USED_W-1:0]  next_end;
    logic [USED_W-1:0]  pix_ext;
    logic               drop;
    logic               accept;
    logic               last_plane;
    logic               m_last;
    logic               wr_en;
    logic               rd_en;
    logic               final_grp;

    always_comb
    begin
        grp_px     = USED_W'(cfg.gb) << 3;
        next_end   = used_reg + grp_px;
        pix_ext    = USED_W'(cfg.pixels);
        // frame done, or no whole group fits
        drop       = next_end > pix_ext;
        final_grp  = (next_end + grp_px) > pix_ext;
        last_plane = (PC_W'(plane_reg) + PC_W'(1)) == cfg.pc;
        m_last     = (GB_W'(m_reg) + GB_W'(1)) == cfg.gb;
        full       = (QCNT_W'(q_count + QCNT_W'(s1_valid_reg))) >= QCNT_W'(QUEUE_DEPTH);
        accept     = push && !full;
        wr_en      = accept && !drop && !last_plane;
        rd_en      = accept && !drop && last_plane;

        plane_next = plane_reg;
        m_next     = m_reg;
        used_next  = used_reg;
        if (cfg.restart)
        begin
            plane_next = '0;
            m_next     = '0;
            used_next  = '0;
        end
        else if (accept && !drop)
        begin
            if (m_last)
            begin
                m_next = '0;
                if (last_plane)
                begin
                    plane_next = '0;
                    used_next  = next_end;
                end
                else
                begin
                    plane_next = plane_reg + PLANE_W'(1);
                end
            end
            else
            begin
                m_next = m_reg + M_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg    <= '0;
            m_reg        <= '0;
            used_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            plane_reg    <= plane_next;
            m_reg        <= m_next;
            used_reg     <= used_next;
            s1_valid_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_byte_reg  <= data_byte;
            s1_pc_reg    <= cfg.pc;
            s1_order_reg <= cfg.lsb_first;
            s1_last_reg  <= final_grp && m_last;
        end
    end

    // row per byte position, one byte lane per leading plane
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[m_reg][plane_reg*BYTE_W +: BYTE_W] <= data_byte;
        if (rd_en)
            rd_row_reg <= store_mem[m_reg];
    end

    always_comb
    begin
        q_push          = s1_valid_reg;
        q_job.row       = rd_row_reg;
        q_job.byte_val  = s1_byte_reg;
        q_job.pc        = s1_pc_reg;
        q_job.lsb_first = s1_order_reg;
        q_job.img_last  = s1_last_reg;
    end

endmodule

@@ hdl/b2p_fifo.sv @@
module b2p_fifo
    import b2p_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  job_t              wr_job,
    input  logic              rd,
    output job_t              rd_job,
    output logic              q_empty,
    output logic [QCNT_W-1:0] count
);

    job_t              q_mem [QUEUE_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_rd;

    assign q_empty = (count_reg == '0);
    assign count   = count_reg;
    assign rd_job  = q_mem[rd_ptr_reg];
    assign do_rd   = rd && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            if (wr && !do_rd)
                count_reg <= count_reg + QCNT_W'(1);
            else if (!wr && do_rd)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            q_mem[wr_ptr_reg] <= wr_job;
    end

endmodule

@@ hdl/b2p_back.sv @@
module b2p_back
    import b2p_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  job_t             q_job,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             empty,
    input  logic             pop,
    output logic [PIX_W-1:0] pixel_index,
    output logic             run_last,
    output logic             image_last
);

    job_t             job_reg;
    logic             job_valid_reg;
    logic [2:0]       cnt_reg;
    logic             out_valid_reg;
    logic [PIX_W-1:0] pix_reg;
    logic             run_last_reg;
    logic             img_last_reg;
    logic             advance;
    logic             take;

    always_comb
    begin
        advance = job_valid_reg && (!out_valid_reg || pop);
        take    = !job_valid_reg || (advance && (cnt_reg == 3'd7));
        q_pop   = take && !q_empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
            if (take)
            begin
                job_valid_reg <= !q_empty;
                cnt_reg       <= '0;
            end
            else if (advance)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            job_reg <= q_job;
        if (advance)
        begin
            pix_reg      <= pixel_of(job_reg, cnt_reg);
            run_last_reg <= (cnt_reg == 3'd7);
            img_last_reg <= (cnt_reg == 3'd7) && job_reg.img_last;
        end
    end

    assign empty       = !out_valid_reg;
    assign pixel_index = pix_reg;
    assign run_last    = run_last_reg;
    assign image_last  = img_last_reg;

endmodule

@@ hdl/bitplane_to_pixel_index_unit.sv @@
// Channel  Direction  Handshake             Payload
// input    in         push / full           data_byte[7:0]
// result   out        empty / pop           pixel_index[3:0], run_last, image_last
// config   in         cfg_valid / cfg_ready cfg_index[1:0], cfg_data[19:0]
//
// A byte of a leading plane is written to the plane store; a last-plane byte
// yields eight items at one per cycle from the serialiser while the result side
// does not stall, so throughput is set by that unit. A last-plane byte passes
// the front stage registers, job queue, job register and output register.
// Reset clears counters and queue; the plane store holds stale data.
// A stalled result side fills the four-entry job queue, then raises full.
module bitplane_to_pixel_index_unit
    import b2p_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [BYTE_W-1:0]     data_byte,
    output logic                  empty,
    input  logic                  pop,
    output logic [PIX_W-1:0]      pixel_index,
    output logic                  run_last,
    output logic                  image_last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg;
    job_t              push_job;
    job_t              head_job;
    logic              q_push;
    logic              q_pop;
    logic              q_empty;
    logic [QCNT_W-1:0] q_count;

    // register file; any write restarts the frame
    b2p_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // front: group position, frame bound, plane store, job build
    b2p_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .q_count   (q_count),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    // decouples the byte side from the pixel side
    b2p_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_job  (push_job),
        .rd      (q_pop),
        .rd_job  (head_job),
        .q_empty (q_empty),
        .count   (q_count)
    );

    // back: eight pixels per job, MSB first, into the output register
    b2p_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_job       (head_job),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .pixel_index (pixel_index),
        .run_last    (run_last),
        .image_last  (image_last)
    );

endmodule
